// ===== rtl/core/ats_pkg.sv =====
`timescale 1ns / 1ps

package ats_pkg;

   // geometry defaults
   localparam int VISIBLE_ROWS_DEF   = 13;
   localparam int VISIBLE_COLS_DEF   = 52;
   localparam int HISTORY_LINES_DEF  = 120;
   localparam int SEQ_BUFFER_LEN_DEF = 24;
   localparam int MAX_PARAMS_DEF     = 8;

   // port widths
   localparam int REQ_W = 24;   // 21 field bits, padded to bytes
   localparam int RSP_W = 40;
   localparam int CSR_W = 4;

   // register indexes
   localparam logic REG_DEFAULT_FG = 1'b0;
   localparam logic REG_DEFAULT_BG = 1'b1;

   // reset values
   localparam logic [3:0] FG_RESET   = 4'd7;
   localparam logic [3:0] BG_RESET   = 4'd0;
   localparam logic [7:0] ATTR_RESET = 8'h70;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   // function codes
   localparam logic [2:0] FN_BYTE = 3'd0;
   localparam logic [2:0] FN_BACK = 3'd1;
   localparam logic [2:0] FN_FWD  = 3'd2;
   localparam logic [2:0] FN_SNAP = 3'd3;
   localparam logic [2:0] FN_READ = 3'd4;

   // character codes
   localparam logic [7:0] CH_ESC    = 8'h1B;
   localparam logic [7:0] CH_BEL    = 8'h07;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] FINAL_LO  = 8'h40;
   localparam logic [7:0] FINAL_HI  = 8'h7E;
   localparam logic [7:0] CSI_SGR   = 8'h6D;  // m
   localparam logic [7:0] CSI_CUP   = 8'h48;  // H
   localparam logic [7:0] CSI_HVP   = 8'h66;  // f
   localparam logic [7:0] CSI_ED    = 8'h4A;  // J
   localparam logic [7:0] CSI_EL    = 8'h4B;  // K
   localparam logic [7:0] CSI_CUU   = 8'h41;  // A
   localparam logic [7:0] CSI_CUD   = 8'h42;  // B
   localparam logic [7:0] CSI_CUF   = 8'h43;  // C
   localparam logic [7:0] CSI_CUB   = 8'h44;  // D

   localparam logic [15:0] NUM_SAT = 16'hFFFF;

   typedef enum logic [1:0] {MD_NONE, MD_ESC, MD_CSI, MD_OSC} mode_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_CLEAR, OP_STEP, OP_NEWLINE,
      OP_BLANK, OP_PRINT, OP_SGR, OP_READ, OP_RESP
   } op_type;

   typedef enum logic [2:0] {
      KD_SIMPLE, KD_NEWLINE, KD_PRINT, KD_WRAP, KD_READ, KD_SGR, KD_ERASE
   } kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DECODE, ST_BLANK, ST_WRITE, ST_SGR, ST_READ, ST_DONE
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     nl_scroll;
      logic     blank_last;
      logic     sgr_last;
      logic     clear_last;
      logic     rsp_busy;
   } stat_type;

endpackage

// ===== rtl/core/ats_ctrl.sv =====
`timescale 1ns / 1ps

module ats_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  ats_pkg::stat_type stat,
   output ats_pkg::cmd_type  cmd
);

   ats_pkg::state_type state_ff, state_in;
   logic pend_ff, pend_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ats_pkg::ST_CLEAR;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   // sequencing
   always_comb begin
      state_in   = state_ff;
      pend_in    = pend_ff;
      cmd.op     = ats_pkg::OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ats_pkg::ST_CLEAR: begin
            cmd.op = ats_pkg::OP_CLEAR;
            if (stat.clear_last) state_in = ats_pkg::ST_IDLE;
         end
         ats_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = ats_pkg::OP_LOAD;
               state_in = ats_pkg::ST_DECODE;
            end
         end
         ats_pkg::ST_DECODE: begin
            pend_in = 1'b0;
            unique case (stat.kind)
               ats_pkg::KD_SIMPLE: begin
                  cmd.op   = ats_pkg::OP_STEP;
                  state_in = ats_pkg::ST_DONE;
               end
               ats_pkg::KD_NEWLINE: begin
                  cmd.op   = ats_pkg::OP_NEWLINE;
                  state_in = stat.nl_scroll ? ats_pkg::ST_BLANK : ats_pkg::ST_DONE;
               end
               ats_pkg::KD_PRINT: begin
                  cmd.op   = ats_pkg::OP_PRINT;
                  state_in = ats_pkg::ST_DONE;
               end
               ats_pkg::KD_WRAP: begin
                  // newline first, then the character
                  cmd.op   = ats_pkg::OP_NEWLINE;
                  pend_in  = 1'b1;
                  state_in = stat.nl_scroll ? ats_pkg::ST_BLANK : ats_pkg::ST_WRITE;
               end
               ats_pkg::KD_READ: begin
                  cmd.op   = ats_pkg::OP_READ;
                  state_in = ats_pkg::ST_READ;
               end
               ats_pkg::KD_SGR: begin
                  cmd.op   = ats_pkg::OP_STEP;
                  state_in = ats_pkg::ST_SGR;
               end
               ats_pkg::KD_ERASE: begin
                  cmd.op   = ats_pkg::OP_STEP;
                  state_in = ats_pkg::ST_BLANK;
               end
               default: begin
                  state_in = ats_pkg::ST_DONE;
               end
            endcase
         end
         ats_pkg::ST_BLANK: begin
            cmd.op = ats_pkg::OP_BLANK;
            if (stat.blank_last) state_in = pend_ff ? ats_pkg::ST_WRITE : ats_pkg::ST_DONE;
         end
         ats_pkg::ST_WRITE: begin
            cmd.op   = ats_pkg::OP_PRINT;
            state_in = ats_pkg::ST_DONE;
         end
         ats_pkg::ST_SGR: begin
            cmd.op = ats_pkg::OP_SGR;
            if (stat.sgr_last) state_in = ats_pkg::ST_DONE;
         end
         ats_pkg::ST_READ: begin
            state_in = ats_pkg::ST_DONE;
         end
         ats_pkg::ST_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.op   = ats_pkg::OP_RESP;
               state_in = ats_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ats_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/ats_datapath.sv =====
`timescale 1ns / 1ps

module ats_datapath #(
   parameter int VISIBLE_ROWS   = ats_pkg::VISIBLE_ROWS_DEF,
   parameter int VISIBLE_COLS   = ats_pkg::VISIBLE_COLS_DEF,
   parameter int HISTORY_LINES  = ats_pkg::HISTORY_LINES_DEF,
   parameter int SEQ_BUFFER_LEN = ats_pkg::SEQ_BUFFER_LEN_DEF,
   parameter int MAX_PARAMS     = ats_pkg::MAX_PARAMS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ats_pkg::cmd_type         cmd,
   output ats_pkg::stat_type        stat,
   input  logic [ats_pkg::REQ_W-1:0] req_tdata,
   input  logic                     csr_valid,
   input  logic                     csr_index,
   input  logic [ats_pkg::CSR_W-1:0] csr_data,
   input  logic                     rsp_tready,
   output logic                     rsp_tvalid,
   output logic [ats_pkg::RSP_W-1:0] rsp_tdata
);

   localparam int RW    = $clog2(VISIBLE_ROWS);
   localparam int CW    = $clog2(VISIBLE_COLS + 1);
   localparam int LW    = $clog2(HISTORY_LINES + 1);
   localparam int SW    = $clog2(HISTORY_LINES);
   localparam int CELLS = HISTORY_LINES * VISIBLE_COLS;
   localparam int AW    = $clog2(CELLS);
   localparam int SLW   = $clog2(SEQ_BUFFER_LEN);
   localparam int PW    = $clog2(MAX_PARAMS + 1);
   localparam int PD    = MAX_PARAMS + 2;

   // latched item
   logic [2:0] func_ff, func_in;
   logic [7:0] byte_ff, byte_in;
   logic [3:0] rrow_ff, rrow_in;
   logic [5:0] rcol_ff, rcol_in;

   // terminal state
   ats_pkg::mode_type mode_ff, mode_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [LW-1:0]  view_ff, view_in;
   logic [LW-1:0]  total_ff, total_in;
   logic [SW-1:0]  base_ff, base_in;
   logic [SLW-1:0] seqlen_ff, seqlen_in;
   logic [PW-1:0]  np_ff, np_in;
   logic [15:0]    v_ff, v_in;
   logic           any_ff, any_in;
   logic [PD*16-1:0] pv_ff, pv_in;
   logic [PW-1:0]  rem_ff, rem_in;
   logic [3:0]     fg_ff, fg_in, bg_ff, bg_in, dfg_ff, dfg_in, dbg_ff, dbg_in;
   logic           bold_ff, bold_in;

   // blank walker and clearing pass
   logic [LW-1:0]  bl_line_ff, bl_line_in;
   logic [CW-1:0]  bl_col_ff, bl_col_in;
   logic [RW:0]    bl_rows_ff, bl_rows_in;
   logic [AW-1:0]  clr_ff, clr_in;

   // read back and result
   logic           hit_ff, hit_in;
   logic [15:0]    rd_q;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [ats_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic [15:0] mem [CELLS];

   // derived values
   logic [7:0]  cur_attr;
   logic [3:0]  fg_eff;
   logic [LW-1:0] live_top, read_top, new_total;
   logic        is_final, is_digit, push, in_range;
   logic [PW-1:0] np_fin;
   logic [15:0] p0, p1, p2, step, prow, pcol;
   logic [19:0] vmul;
   logic [16:0] row_sum, col_sum;
   logic [CW:0] tab_sum;
   logic [15:0] sg_p, sg_n;
   logic [3:0]  sg_ci;
   logic [2:0]  sg_sh;
   logic        sg_ext;

   // cell addressing
   logic [LW-1:0] sel_line;
   logic [CW-1:0] sel_col;
   logic [LW:0]   slot_sum;
   logic [SW-1:0] slot;
   logic [AW-1:0] cell_addr, wr_addr;
   logic [15:0]   wr_data;
   logic          wr_en, rd_en;

   assign fg_eff   = (bold_ff && !fg_ff[3]) ? (fg_ff | 4'd8) : fg_ff;
   assign cur_attr = {fg_eff, bg_ff};
   assign live_top = total_ff - LW'(VISIBLE_ROWS);
   assign read_top = (live_top > view_ff) ? (live_top - view_ff) : '0;
   assign new_total = (total_ff < LW'(HISTORY_LINES)) ? (total_ff + LW'(1)) : total_ff;
   assign is_final = (byte_ff >= ats_pkg::FINAL_LO) && (byte_ff <= ats_pkg::FINAL_HI);
   assign is_digit = (byte_ff >= ats_pkg::CH_ZERO) && (byte_ff <= ats_pkg::CH_NINE);
   assign in_range = (32'(rrow_ff) < VISIBLE_ROWS) && (32'(rcol_ff) < VISIBLE_COLS);

   // parameter list as it stands once the final byte closes it
   assign push   = (any_ff || (np_ff != '0)) && (32'(np_ff) < MAX_PARAMS);
   assign np_fin = np_ff + PW'(push);
   assign p0     = (np_ff != '0) ? pv_ff[15:0] : v_ff;
   assign p1     = (32'(np_ff) >= 2) ? pv_ff[31:16] : v_ff;
   assign p2     = pv_ff[47:32];
   assign step   = (p0 != '0) ? p0 : 16'd1;
   assign vmul   = 20'(v_ff) * 20'd10 + 20'(byte_ff - ats_pkg::CH_ZERO);

   assign prow    = (p0 != '0) ? (p0 - 16'd1) : '0;
   assign pcol    = ((32'(np_fin) > 1) && (p1 != '0)) ? (p1 - 16'd1) : '0;
   assign row_sum = 17'(row_ff) + 17'(step);
   assign col_sum = 17'(col_ff) + 17'(step);
   assign tab_sum = ((CW+1)'(col_ff >> 3) + (CW+1)'(1)) << 3;

   // one SGR step on the head of the parameter list
   assign sg_p   = pv_ff[15:0];
   assign sg_ext = (32'(rem_ff) > 1) && ((sg_p == 16'd38) || (sg_p == 16'd48));
   assign sg_n   = (32'(rem_ff) > 2) ? p2 : '0;
   assign sg_ci  = (sg_n < 16'd16) ? sg_n[3:0] : ((sg_n < 16'd244) ? 4'd7 : 4'd15);
   always_comb begin
      if (sg_ext && (pv_ff[31:16] == 16'd5)) sg_sh = 3'd3;
      else if (sg_ext && (pv_ff[31:16] == 16'd2)) sg_sh = 3'd5;
      else sg_sh = 3'd1;
   end

   // line select and ring slot
   always_comb begin
      unique case (cmd.op)
         ats_pkg::OP_PRINT: begin
            sel_line = live_top + LW'(row_ff);
            sel_col  = col_ff;
         end
         ats_pkg::OP_READ: begin
            sel_line = read_top + LW'(rrow_ff);
            sel_col  = CW'(rcol_ff);
         end
         default: begin
            sel_line = bl_line_ff;
            sel_col  = bl_col_ff;
         end
      endcase
   end
   assign slot_sum  = (LW+1)'(base_ff) + (LW+1)'(sel_line);
   assign slot      = (32'(slot_sum) >= HISTORY_LINES) ?
                      SW'(slot_sum - (LW+1)'(HISTORY_LINES)) : SW'(slot_sum);
   assign cell_addr = AW'(AW'(slot) * AW'(VISIBLE_COLS) + AW'(sel_col));

   assign wr_en   = (cmd.op == ats_pkg::OP_CLEAR) || (cmd.op == ats_pkg::OP_BLANK) ||
                    (cmd.op == ats_pkg::OP_PRINT);
   assign wr_addr = (cmd.op == ats_pkg::OP_CLEAR) ? clr_ff : cell_addr;
   always_comb begin
      unique case (cmd.op)
         ats_pkg::OP_CLEAR: wr_data = {ats_pkg::ATTR_RESET, ats_pkg::CH_SPACE};
         ats_pkg::OP_PRINT: wr_data = {cur_attr, byte_ff};
         default:           wr_data = {cur_attr, ats_pkg::CH_SPACE};
      endcase
   end
   assign rd_en = (cmd.op == ats_pkg::OP_READ) && in_range;

   // cell memory
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_q <= mem[cell_addr];
   end

   // status
   always_comb begin
      stat.kind = ats_pkg::KD_SIMPLE;
      priority if (func_ff == ats_pkg::FN_READ) begin
         stat.kind = ats_pkg::KD_READ;
      end else if (func_ff == ats_pkg::FN_BYTE && mode_ff == ats_pkg::MD_NONE) begin
         if (byte_ff == ats_pkg::CH_LF) stat.kind = ats_pkg::KD_NEWLINE;
         else if (byte_ff >= ats_pkg::CH_SPACE)
            stat.kind = (32'(col_ff) >= VISIBLE_COLS) ? ats_pkg::KD_WRAP : ats_pkg::KD_PRINT;
      end else if (func_ff == ats_pkg::FN_BYTE && mode_ff == ats_pkg::MD_CSI && is_final) begin
         if (byte_ff == ats_pkg::CSI_SGR) stat.kind = ats_pkg::KD_SGR;
         else if (byte_ff == ats_pkg::CSI_ED) stat.kind = ats_pkg::KD_ERASE;
         else if (byte_ff == ats_pkg::CSI_EL && 32'(col_ff) < VISIBLE_COLS)
            stat.kind = ats_pkg::KD_ERASE;
      end else begin
         stat.kind = ats_pkg::KD_SIMPLE;
      end
   end
   assign stat.nl_scroll  = (32'(row_ff) == VISIBLE_ROWS - 1);
   assign stat.blank_last = (32'(bl_col_ff) == VISIBLE_COLS - 1) && (bl_rows_ff == (RW+1)'(1));
   assign stat.sgr_last   = (rem_ff <= PW'(sg_sh));
   assign stat.clear_last = (32'(clr_ff) == CELLS - 1);
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_tready;

   // next state
   always_comb begin
      func_in = func_ff;  byte_in = byte_ff;  rrow_in = rrow_ff;  rcol_in = rcol_ff;
      mode_in = mode_ff;  row_in = row_ff;    col_in = col_ff;    view_in = view_ff;
      total_in = total_ff; base_in = base_ff; seqlen_in = seqlen_ff;
      np_in = np_ff;      v_in = v_ff;        any_in = any_ff;    pv_in = pv_ff;
      rem_in = rem_ff;    fg_in = fg_ff;      bg_in = bg_ff;      bold_in = bold_ff;
      dfg_in = dfg_ff;    dbg_in = dbg_ff;
      bl_line_in = bl_line_ff; bl_col_in = bl_col_ff; bl_rows_in = bl_rows_ff;
      clr_in = clr_ff;    hit_in = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      // register writes
      if (csr_valid) begin
         if (csr_index == ats_pkg::REG_DEFAULT_FG) dfg_in = csr_data;
         else dbg_in = csr_data;
      end

      unique case (cmd.op)
         ats_pkg::OP_LOAD: begin
            func_in = req_tdata[2:0];
            byte_in = req_tdata[10:3];
            rrow_in = req_tdata[14:11];
            rcol_in = req_tdata[20:15];
            hit_in  = 1'b0;
         end
         ats_pkg::OP_CLEAR: begin
            clr_in = clr_ff + AW'(1);
         end
         ats_pkg::OP_STEP: begin
            unique case (func_ff)
               ats_pkg::FN_BACK: if (view_ff < live_top) view_in = view_ff + LW'(1);
               ats_pkg::FN_FWD:  if (view_ff != '0) view_in = view_ff - LW'(1);
               ats_pkg::FN_SNAP: view_in = '0;
               ats_pkg::FN_BYTE: begin
                  unique case (mode_ff)
                     ats_pkg::MD_ESC: begin
                        if (byte_ff == ats_pkg::CH_LBRACK) begin
                           mode_in = ats_pkg::MD_CSI;
                           seqlen_in = '0; np_in = '0; v_in = '0; any_in = 1'b0;
                        end else if (byte_ff == ats_pkg::CH_RBRACK) begin
                           mode_in = ats_pkg::MD_OSC;
                        end else begin
                           mode_in = ats_pkg::MD_NONE;
                        end
                     end
                     ats_pkg::MD_OSC: begin
                        if (byte_ff == ats_pkg::CH_BEL || byte_ff == ats_pkg::CH_ESC)
                           mode_in = ats_pkg::MD_NONE;
                     end
                     ats_pkg::MD_CSI: begin
                        if (is_final) begin
                           mode_in = ats_pkg::MD_NONE;
                           // close the parameter list
                           for (int k = 0; k < MAX_PARAMS; k++) begin
                              if (push && 32'(np_ff) == k) pv_in[k*16 +: 16] = v_ff;
                           end
                           if (np_fin == '0) begin
                              pv_in[15:0] = '0;
                              rem_in = PW'(1);
                           end else begin
                              rem_in = np_fin;
                           end
                           if (byte_ff == ats_pkg::CSI_CUP || byte_ff == ats_pkg::CSI_HVP) begin
                              row_in = (32'(prow) >= VISIBLE_ROWS) ? RW'(VISIBLE_ROWS - 1) :
                                       RW'(prow);
                              col_in = (32'(pcol) >= VISIBLE_COLS) ? CW'(VISIBLE_COLS - 1) :
                                       CW'(pcol);
                           end else if (byte_ff == ats_pkg::CSI_ED) begin
                              bl_line_in = live_top;
                              bl_col_in  = '0;
                              bl_rows_in = (RW+1)'(VISIBLE_ROWS);
                              row_in = '0;
                              col_in = '0;
                           end else if (byte_ff == ats_pkg::CSI_EL) begin
                              bl_line_in = live_top + LW'(row_ff);
                              bl_col_in  = col_ff;
                              bl_rows_in = (RW+1)'(1);
                           end else if (byte_ff == ats_pkg::CSI_CUU) begin
                              row_in = (16'(row_ff) >= step) ? RW'(16'(row_ff) - step) : '0;
                           end else if (byte_ff == ats_pkg::CSI_CUD) begin
                              row_in = (32'(row_sum) >= VISIBLE_ROWS) ?
                                       RW'(VISIBLE_ROWS - 1) : RW'(row_sum);
                           end else if (byte_ff == ats_pkg::CSI_CUF) begin
                              col_in = (32'(col_sum) >= VISIBLE_COLS) ?
                                       CW'(VISIBLE_COLS - 1) : CW'(col_sum);
                           end else if (byte_ff == ats_pkg::CSI_CUB) begin
                              col_in = (16'(col_ff) >= step) ? CW'(16'(col_ff) - step) : '0;
                           end
                        end else if (32'(seqlen_ff) < SEQ_BUFFER_LEN - 1) begin
                           // buffered byte, parsed as it arrives
                           seqlen_in = seqlen_ff + SLW'(1);
                           if (32'(np_ff) < MAX_PARAMS) begin
                              if (is_digit) begin
                                 v_in   = (vmul > 20'(ats_pkg::NUM_SAT)) ? ats_pkg::NUM_SAT :
                                          vmul[15:0];
                                 any_in = 1'b1;
                              end else if (byte_ff == ats_pkg::CH_SEMI) begin
                                 for (int k = 0; k < MAX_PARAMS; k++) begin
                                    if (32'(np_ff) == k) pv_in[k*16 +: 16] = v_ff;
                                 end
                                 np_in  = np_ff + PW'(1);
                                 v_in   = '0;
                                 any_in = 1'b0;
                              end
                           end
                        end
                     end
                     default: begin
                        if (byte_ff == ats_pkg::CH_ESC) mode_in = ats_pkg::MD_ESC;
                        else if (byte_ff == ats_pkg::CH_CR) col_in = '0;
                        else if (byte_ff == ats_pkg::CH_BS) begin
                           if (col_ff != '0) col_in = col_ff - CW'(1);
                        end else if (byte_ff == ats_pkg::CH_TAB) begin
                           col_in = (32'(tab_sum) >= VISIBLE_COLS) ? CW'(VISIBLE_COLS - 1) :
                                    CW'(tab_sum);
                        end
                     end
                  endcase
               end
               default: ;
            endcase
         end
         ats_pkg::OP_NEWLINE: begin
            col_in = '0;
            if (stat.nl_scroll) begin
               // add a line at the bottom of the ring
               total_in = new_total;
               if (total_ff == LW'(HISTORY_LINES))
                  base_in = (32'(base_ff) == HISTORY_LINES - 1) ? '0 : (base_ff + SW'(1));
               if (view_ff != '0 && view_ff < (new_total - LW'(VISIBLE_ROWS)))
                  view_in = view_ff + LW'(1);
               bl_line_in = new_total - LW'(1);
               bl_col_in  = '0;
               bl_rows_in = (RW+1)'(1);
            end else begin
               row_in = row_ff + RW'(1);
            end
         end
         ats_pkg::OP_BLANK: begin
            if (32'(bl_col_ff) == VISIBLE_COLS - 1) begin
               bl_col_in  = '0;
               bl_line_in = bl_line_ff + LW'(1);
               bl_rows_in = bl_rows_ff - (RW+1)'(1);
            end else begin
               bl_col_in = bl_col_ff + CW'(1);
            end
         end
         ats_pkg::OP_PRINT: begin
            col_in = col_ff + CW'(1);
         end
         ats_pkg::OP_SGR: begin
            if (sg_ext) begin
               if (pv_ff[31:16] == 16'd5) begin
                  if (sg_p == 16'd38) fg_in = sg_ci;
                  else bg_in = sg_ci;
               end
            end else if (sg_p == 16'd0) begin
               fg_in = dfg_ff; bg_in = dbg_ff; bold_in = 1'b0;
            end else if (sg_p == 16'd1) bold_in = 1'b1;
            else if (sg_p == 16'd22) bold_in = 1'b0;
            else if (sg_p == 16'd39) fg_in = dfg_ff;
            else if (sg_p == 16'd49) bg_in = dbg_ff;
            else if (sg_p >= 16'd30 && sg_p <= 16'd37) fg_in = 4'(sg_p - 16'd30);
            else if (sg_p >= 16'd90 && sg_p <= 16'd97) fg_in = 4'(sg_p - 16'd82);
            else if (sg_p >= 16'd40 && sg_p <= 16'd47) bg_in = 4'(sg_p - 16'd40);
            else if (sg_p >= 16'd100 && sg_p <= 16'd107) bg_in = 4'(sg_p - 16'd92);
            pv_in  = pv_ff >> (16 * sg_sh);
            rem_in = (rem_ff > PW'(sg_sh)) ? (rem_ff - PW'(sg_sh)) : '0;
         end
         ats_pkg::OP_READ: begin
            hit_in = in_range;
         end
         ats_pkg::OP_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {hit_ff ? rd_q[15:8] : 8'd0, hit_ff ? rd_q[7:0] : 8'd0,
                            7'(total_ff), 7'(view_ff), 6'(col_ff), 4'(row_ff)};
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ats_pkg::MD_NONE;
         row_ff <= '0; col_ff <= '0; view_ff <= '0;
         total_ff <= LW'(VISIBLE_ROWS); base_ff <= '0;
         seqlen_ff <= '0; np_ff <= '0; v_ff <= '0; any_ff <= 1'b0; rem_ff <= '0;
         fg_ff <= ats_pkg::FG_RESET; bg_ff <= ats_pkg::BG_RESET; bold_ff <= 1'b0;
         dfg_ff <= ats_pkg::FG_RESET; dbg_ff <= ats_pkg::BG_RESET;
         bl_rows_ff <= '0; clr_ff <= '0; hit_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         row_ff <= row_in; col_ff <= col_in; view_ff <= view_in;
         total_ff <= total_in; base_ff <= base_in;
         seqlen_ff <= seqlen_in; np_ff <= np_in; v_ff <= v_in; any_ff <= any_in;
         rem_ff <= rem_in;
         fg_ff <= fg_in; bg_ff <= bg_in; bold_ff <= bold_in;
         dfg_ff <= dfg_in; dbg_ff <= dbg_in;
         bl_rows_ff <= bl_rows_in; clr_ff <= clr_in; hit_ff <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff <= func_in; byte_ff <= byte_in; rrow_ff <= rrow_in; rcol_ff <= rcol_in;
      pv_ff <= pv_in;
      bl_line_ff <= bl_line_in; bl_col_ff <= bl_col_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/core/ansi_terminal_scrollback_core.sv =====
`timescale 1ns / 1ps
// A plain item passes the accept, decode and result states; a read adds the read state.
// A newline that scrolls blanks the new line one cell per cycle, as does an erase to end
// of line for each cell from the cursor on, and an erase screen for all visible cells.
// SGR applies one parameter group per cycle.
// Throughput: one item at a time; the next is taken while the last result waits.
// Reset: synchronous; then a clearing pass writes all HISTORY_LINES*VISIBLE_COLS cells.

module ansi_terminal_scrollback_core #(
   parameter int VISIBLE_ROWS   = ats_pkg::VISIBLE_ROWS_DEF,
   parameter int VISIBLE_COLS   = ats_pkg::VISIBLE_COLS_DEF,
   parameter int HISTORY_LINES  = ats_pkg::HISTORY_LINES_DEF,
   parameter int SEQ_BUFFER_LEN = ats_pkg::SEQ_BUFFER_LEN_DEF,
   parameter int MAX_PARAMS     = ats_pkg::MAX_PARAMS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // func[2:0], data_byte[10:3], read_row[14:11], read_col[20:15]
   input  logic [ats_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // cursor_row[3:0], cursor_col[9:4], view_back[16:10], lines_held[23:17],
   // cell_char[31:24], cell_attr[39:32]
   output logic [ats_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_index,
   input  logic [ats_pkg::CSR_W-1:0] csr_data
);

   ats_pkg::cmd_type  cmd;
   ats_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   ats_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ats_datapath #(
      .VISIBLE_ROWS   (VISIBLE_ROWS),
      .VISIBLE_COLS   (VISIBLE_COLS),
      .HISTORY_LINES  (HISTORY_LINES),
      .SEQ_BUFFER_LEN (SEQ_BUFFER_LEN),
      .MAX_PARAMS     (MAX_PARAMS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   // no item is taken during the clearing pass
   a_clear_blocks: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("item accepted during clearing pass");

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item accepted while busy");

   // cursor stays on the screen
   a_cursor_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[3:0]) < VISIBLE_ROWS))
      else $error("cursor row out of range");

   // view never goes past the oldest line
   a_view: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((32'(rsp_tdata[23:17]) >= VISIBLE_ROWS) &&
                      (32'(rsp_tdata[16:10]) + VISIBLE_ROWS <= 32'(rsp_tdata[23:17]))))
      else $error("view offset beyond history");

endmodule
